@@ hw/rtl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the serial packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int MAX_PAYLOAD_BYTES = 1024;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int ADDR_W     = 16;
  localparam int TOTAL_W    = 16;
  localparam int REM_W      = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int IN_TDATA_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FRAME_OVERHEAD = 10;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hAA;
  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hBB;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'hCC;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BCD_MODE = 2'd1;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] sequence_req;
    logic              use_given_address;
    logic [ADDR_W-1:0] given_address;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
  } addr_bytes_t;

endpackage

@@ hw/rtl/spf_addr_conv.sv @@
// ----------------------------------------------------------------------------
// spf_addr_conv
// Three-stage pipe that turns the station address into its header bytes:
// raw bytes in hex mode, or bcd of (address/100)%100 and address%100.
// ----------------------------------------------------------------------------
module spf_addr_conv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [spf_pkg::ADDR_W-1:0]       station_address,
  input  logic                             bcd_mode,
  output spf_pkg::addr_bytes_t             station_bytes
);
  import spf_pkg::*;

  // reciprocal of 100 scaled by 2^23, exact for 16-bit values
  localparam int Recip100Shift = 23;
  localparam logic [32:0] Recip100 = 33'(((1 << Recip100Shift) + 99) / 100);
  // reciprocal of 100 scaled by 2^12, exact below 800 in the 15-bit product
  localparam logic [14:0] RecipSmall = 15'd41;
  localparam int RecipSmallShift = 12;

  localparam int QUOT_W = 10;
  localparam int DIG_W  = 7;

  function automatic logic [BYTE_W-1:0] to_bcd(input logic [DIG_W-1:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [DIG_W-1:0] ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - DIG_W'(tens * 4'd10);
    return {tens, ones[3:0]};
  endfunction

  logic [32:0]        prod_a;
  logic [QUOT_W-1:0]  quot_nxt;
  logic [QUOT_W-1:0]  quot_r;
  logic [ADDR_W-1:0]  addr_a_r;
  logic               mode_a_r;

  logic [ADDR_W-1:0]  lo_full;
  logic [14:0]        prod_b;
  logic [2:0]         quot2;
  logic [QUOT_W-1:0]  hi_full;
  logic [DIG_W-1:0]   hi_val_r;
  logic [DIG_W-1:0]   lo_val_r;
  logic [ADDR_W-1:0]  addr_b_r;
  logic               mode_b_r;

  addr_bytes_t        bytes_nxt;
  addr_bytes_t        bytes_r;

  always_comb begin
    prod_a   = 33'(station_address) * Recip100;
    quot_nxt = prod_a[Recip100Shift +: QUOT_W];

    lo_full  = addr_a_r - ADDR_W'(16'(quot_r) * 16'd100);
    prod_b   = 15'(quot_r) * RecipSmall;
    quot2    = prod_b[RecipSmallShift +: 3];
    hi_full  = quot_r - QUOT_W'(10'(quot2) * 10'd100);

    if (mode_b_r) begin
      bytes_nxt.hi = to_bcd(hi_val_r);
      bytes_nxt.lo = to_bcd(lo_val_r);
    end else begin
      bytes_nxt.hi = addr_b_r[ADDR_W-1:BYTE_W];
      bytes_nxt.lo = addr_b_r[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_a_r <= 1'b0;
      mode_b_r <= 1'b0;
    end else begin
      mode_a_r <= bcd_mode;
      mode_b_r <= mode_a_r;
    end
    quot_r   <= quot_nxt;
    addr_a_r <= station_address;
    hi_val_r <= hi_full[DIG_W-1:0];
    lo_val_r <= lo_full[DIG_W-1:0];
    addr_b_r <= addr_a_r;
    bytes_r  <= bytes_nxt;
  end

  assign station_bytes = bytes_r;

endmodule

@@ hw/rtl/spf_seq.sv @@
// ----------------------------------------------------------------------------
// spf_seq
// Packet sequencer: walks the bytes one request causes, keeps the open
// packet state and the running xor, and drives the output byte register.
// ----------------------------------------------------------------------------
module spf_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  spf_pkg::item_t               item,
  output logic                         item_pop,
  input  spf_pkg::addr_bytes_t         station_bytes,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [spf_pkg::BYTE_W-1:0]   out_tdata,
  output logic                         out_tlast
);
  import spf_pkg::*;

  typedef enum logic [3:0] {
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
    ST_PL, ST_T0, ST_T1, ST_T2
  } step_t;

  localparam logic [TOTAL_W-1:0] MaxLen = TOTAL_W'(MAX_PAYLOAD_BYTES);

  step_t             step_r, step_nxt, cur_step;
  logic              mid_r, mid_nxt;
  logic              open_r, open_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_dec;
  logic [BYTE_W-1:0] xor_r, xor_nxt, xor_base;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic [TOTAL_W-1:0] plen_ext, plen_sat, total;
  logic [BYTE_W-1:0]  addr_hi, addr_lo, byte_val;
  logic               out_ok, drop, emit;

  always_comb begin
    plen_ext = TOTAL_W'(item.payload_length);
    plen_sat = (plen_ext > MaxLen) ? MaxLen : plen_ext;
    total    = plen_sat + TOTAL_W'(FRAME_OVERHEAD);

    if (item.use_given_address) begin
      addr_hi = item.given_address[ADDR_W-1:BYTE_W];
      addr_lo = item.given_address[BYTE_W-1:0];
    end else begin
      addr_hi = station_bytes.hi;
      addr_lo = station_bytes.lo;
    end

    if (mid_r) begin
      cur_step = step_r;
    end else if (item.operation == OP_PAYLOAD) begin
      cur_step = ST_PL;
    end else begin
      cur_step = ST_H0;
    end

    out_ok = !out_valid_r || out_tready;
    drop   = item_valid && !mid_r && (item.operation == OP_PAYLOAD) && !open_r;
    emit   = item_valid && !drop && out_ok;

    case (cur_step)
      ST_H0:   byte_val = SYNC_BYTE;
      ST_H1:   byte_val = HEADER_BYTE;
      ST_H2:   byte_val = item.sequence_req;
      ST_H3:   byte_val = addr_hi;
      ST_H4:   byte_val = addr_lo;
      ST_H5:   byte_val = total[2*BYTE_W-1:BYTE_W];
      ST_H6:   byte_val = total[BYTE_W-1:0];
      ST_PL:   byte_val = item.payload_byte;
      ST_T0:   byte_val = SYNC_BYTE;
      ST_T1:   byte_val = TRAILER_BYTE;
      ST_T2:   byte_val = xor_r;
      default: byte_val = '0;
    endcase

    xor_base = (cur_step == ST_H0) ? '0 : xor_r;
    rem_dec  = rem_r - REM_W'(1);

    step_nxt      = step_r;
    mid_nxt       = mid_r;
    open_nxt      = open_r;
    rem_nxt       = rem_r;
    xor_nxt       = xor_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    item_pop      = drop;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = byte_val;
      out_last_nxt  = (cur_step == ST_T2);
      xor_nxt       = xor_base ^ byte_val;
      mid_nxt       = 1'b1;
      unique case (cur_step)
        ST_H0: step_nxt = ST_H1;
        ST_H1: step_nxt = ST_H2;
        ST_H2: step_nxt = ST_H3;
        ST_H3: step_nxt = ST_H4;
        ST_H4: step_nxt = ST_H5;
        ST_H5: step_nxt = ST_H6;
        ST_H6: begin
          if (plen_sat == '0) begin
            step_nxt = ST_T0;
          end else begin
            mid_nxt  = 1'b0;
            item_pop = 1'b1;
            open_nxt = 1'b1;
            rem_nxt  = REM_W'(plen_sat);
          end
        end
        ST_PL: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            step_nxt = ST_T0;
          end else begin
            mid_nxt  = 1'b0;
            item_pop = 1'b1;
          end
        end
        ST_T0: step_nxt = ST_T1;
        ST_T1: step_nxt = ST_T2;
        ST_T2: begin
          mid_nxt  = 1'b0;
          item_pop = 1'b1;
          open_nxt = 1'b0;
          rem_nxt  = '0;
          xor_nxt  = '0;
        end
        default: step_nxt = ST_H0;
      endcase
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_H0;
      mid_r       <= 1'b0;
      open_r      <= 1'b0;
      rem_r       <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      mid_r       <= mid_nxt;
      open_r      <= open_nxt;
      rem_r       <= rem_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/serial_packet_framer_xor.sv @@
// ----------------------------------------------------------------------------
// serial_packet_framer_xor
// Frames payload bytes into packets with a seven-byte header and an
// xor checksum trailer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in_     | in_tvalid/in_tready  | tuser: operation; tdata: byte, length, seq, addr
//  out_    | out_tvalid/out_tready| tdata: packet byte; tlast: checksum byte
//  cfg_    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  one output byte per cycle from a single byte register while out_tready is high
//  and requests wait: a start gives seven bytes (ten with an empty payload), a
//  payload byte one, the last four; one with no open packet is dropped with no output
//  synchronous active-low reset, no clearing pass; cfg_ready is always high
//  a new station address reaches the header bytes via station_address_r and u_addr_conv
//  a stalled output holds the input register, which then drops in_tready
// ----------------------------------------------------------------------------
module serial_packet_framer_xor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // payload_byte, payload_length, sequence_req, use_given_address,
  // given_address, zero fill
  input  logic [spf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_byte
  output logic [spf_pkg::BYTE_W-1:0]        out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import spf_pkg::*;

  logic [ADDR_W-1:0] station_address_r, station_address_nxt;
  logic              bcd_mode_r, bcd_mode_nxt;
  logic              in_valid_r, in_valid_nxt;
  item_t             in_item_r, in_item_nxt, in_item;
  logic              item_pop;
  addr_bytes_t       station_bytes;

  assign cfg_ready = 1'b1;
  assign in_tready = !in_valid_r || item_pop;

  always_comb begin
    in_item.operation         = in_tuser;
    in_item.payload_byte      = in_tdata[7:0];
    in_item.payload_length    = in_tdata[18:8];
    in_item.sequence_req      = in_tdata[26:19];
    in_item.use_given_address = in_tdata[27];
    in_item.given_address     = in_tdata[43:28];

    in_valid_nxt = in_valid_r;
    in_item_nxt  = in_item_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end else if (item_pop) begin
      in_valid_nxt = 1'b0;
    end

    station_address_nxt = station_address_r;
    bcd_mode_nxt        = bcd_mode_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STATION_ADDRESS:  station_address_nxt = cfg_data[ADDR_W-1:0];
        REG_ADDRESS_BCD_MODE: bcd_mode_nxt        = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      station_address_r <= '0;
      bcd_mode_r        <= 1'b0;
    end else begin
      in_valid_r        <= in_valid_nxt;
      station_address_r <= station_address_nxt;
      bcd_mode_r        <= bcd_mode_nxt;
    end
    in_item_r <= in_item_nxt;
  end

  spf_addr_conv u_addr_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .station_address (station_address_r),
    .bcd_mode        (bcd_mode_r),
    .station_bytes   (station_bytes)
  );

  spf_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (in_valid_r),
    .item          (in_item_r),
    .item_pop      (item_pop),
    .station_bytes (station_bytes),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

@@ verif/serial_packet_framer_xor_tb.sv @@
// ----------------------------------------------------------------------------
// serial_packet_framer_xor_tb
// Self-checking bench for the packet framer. Start and payload requests are
// queued and driven on the input stream. A model of the framer predicts every
// header, payload and trailer byte. Those bytes are matched in order against
// the output stream under several sender idle and receiver stall patterns,
// and under several station address settings in hex and BCD mode.
// ----------------------------------------------------------------------------
module serial_packet_framer_xor_tb;
  import spf_pkg::*;

  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [IN_TDATA_W-45:0] zero_fill;
    logic [ADDR_W-1:0]      given_address;
    logic                   use_given_address;
    logic [BYTE_W-1:0]      sequence_req;
    logic [LEN_W-1:0]       payload_length;
    logic [BYTE_W-1:0]      payload_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_byte_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  item_t       pending_items[$];
  frame_byte_t frame_bytes_due[$];

  int queued_count   = 0;
  int accepted_count = 0;
  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  logic in_fire      = 1'b0;

  // framer model state
  logic [ADDR_W-1:0] link_station_addr = '0;
  logic              link_bcd_mode     = 1'b0;
  logic              pkt_open          = 1'b0;
  logic [LEN_W-1:0]  pkt_left          = '0;
  logic [BYTE_W-1:0] frame_xor         = '0;

  serial_packet_framer_xor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic logic [BYTE_W-1:0] bcd_pair(input int unsigned v);
    return BYTE_W'((((v / 10) % 10) << 4) | (v % 10));
  endfunction

  function automatic void push_tracked(input logic [BYTE_W-1:0] b);
    frame_xor ^= b;
    frame_bytes_due.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void push_trailer();
    push_tracked(SYNC_BYTE);
    push_tracked(TRAILER_BYTE);
    frame_bytes_due.push_back('{data: frame_xor, last: 1'b1});
    pkt_open  = 1'b0;
    pkt_left  = '0;
    frame_xor = '0;
  endfunction

  function automatic void predict_frame(input logic op, input in_word_t w);
    logic [LEN_W-1:0]   len;
    logic [TOTAL_W-1:0] total;
    logic [BYTE_W-1:0]  hi;
    logic [BYTE_W-1:0]  lo;
    if (op == OP_START) begin
      len = (w.payload_length > MAX_PAYLOAD_BYTES) ? LEN_W'(MAX_PAYLOAD_BYTES)
                                                   : w.payload_length;
      total = TOTAL_W'(len) + TOTAL_W'(FRAME_OVERHEAD);
      if (w.use_given_address) begin
        {hi, lo} = w.given_address;
      end else if (link_bcd_mode) begin
        hi = bcd_pair((link_station_addr / 100) % 100);
        lo = bcd_pair(link_station_addr % 100);
      end else begin
        {hi, lo} = link_station_addr;
      end
      frame_xor = '0;
      push_tracked(SYNC_BYTE);
      push_tracked(HEADER_BYTE);
      push_tracked(w.sequence_req);
      push_tracked(hi);
      push_tracked(lo);
      push_tracked(total[15:8]);
      push_tracked(total[7:0]);
      pkt_open = 1'b1;
      pkt_left = len;
      if (len == 0) push_trailer();
    end else if (pkt_open) begin
      push_tracked(w.payload_byte);
      if (pkt_left > 0) pkt_left--;
      if (pkt_left == 0) push_trailer();
    end
  endfunction

  // driver
  always @(negedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.operation;
        in_tdata  <= {{(IN_TDATA_W-44){1'b0}}, nxt.given_address, nxt.use_given_address,
                      nxt.sequence_req, nxt.payload_length, nxt.payload_byte};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    frame_byte_t due;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STATION_ADDRESS:  link_station_addr = cfg_data;
          REG_ADDRESS_BCD_MODE: link_bcd_mode     = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_frame(in_tuser, in_word_t'(in_tdata));
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %b", out_tdata, out_tlast));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_tdata !== due.data) begin
            report_mismatch($sformatf("byte got %02h want %02h", out_tdata, due.data));
          end
          if (out_tlast !== due.last) begin
            report_mismatch($sformatf("tlast got %b want %b on byte %02h",
                                      out_tlast, due.last, due.data));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic item_t make_start(input int len, input logic [BYTE_W-1:0] seq,
                                       input logic use_given, input logic [ADDR_W-1:0] given);
    item_t it;
    it.operation         = OP_START;
    it.payload_byte      = BYTE_W'($urandom);
    it.payload_length    = LEN_W'(len);
    it.sequence_req      = seq;
    it.use_given_address = use_given;
    it.given_address     = given;
    return it;
  endfunction

  function automatic item_t make_byte(input logic [BYTE_W-1:0] b);
    item_t it;
    it.operation         = OP_PAYLOAD;
    it.payload_byte      = b;
    it.payload_length    = LEN_W'($urandom);
    it.sequence_req      = BYTE_W'($urandom);
    it.use_given_address = 1'($urandom);
    it.given_address     = ADDR_W'($urandom);
    return it;
  endfunction

  function automatic item_t random_start(input int len);
    return make_start(len, BYTE_W'($urandom), 1'($urandom), ADDR_W'($urandom));
  endfunction

  task automatic queue_request(input item_t it);
    pending_items.push_back(it);
    queued_count++;
  endtask

  // mostly whole packets, some cut short, oversized or stray bytes
  task automatic queue_traffic(input int n);
    int made;
    int len;
    int cut;
    int r;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99, 0);
      if (r < 10) begin
        queue_request(make_byte(BYTE_W'($urandom)));
        made += 1;
      end else if (r < 15) begin
        queue_request(random_start($urandom_range(2047, MAX_PAYLOAD_BYTES + 1)));
        cut = $urandom_range(3, 0);
        for (int i = 0; i < cut; i++) queue_request(make_byte(BYTE_W'($urandom)));
        made += 1 + cut;
      end else begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 0);
        cut = ($urandom_range(9, 0) == 0) ? $urandom_range(len, 0) : len;
        queue_request(random_start(len));
        for (int i = 0; i < cut; i++) queue_request(make_byte(BYTE_W'($urandom)));
        made += 1 + cut;
      end
    end
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count) @(negedge clk);
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_station(input logic [ADDR_W-1:0] addr, input logic bcd);
    write_reg(REG_STATION_ADDRESS, addr);
    write_reg(REG_ADDRESS_BCD_MODE, CFG_DATA_W'(bcd));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_traffic(n);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests under reset register values
    queue_request(make_byte(8'h3C));
    queue_request(make_start(0, 8'h00, 1'b0, 16'h0000));
    queue_request(make_start(2, 8'hFF, 1'b1, 16'hFFFF));
    queue_request(make_byte(8'h00));
    queue_request(make_byte(8'hFF));
    queue_request(make_byte(8'h81));
    queue_request(make_start(2047, 8'h5A, 1'b0, 16'hFFFF));
    queue_request(make_byte(8'hA5));
    queue_request(make_byte(8'h5A));
    queue_request(make_start(MAX_PAYLOAD_BYTES, 8'h01, 1'b1, 16'h8000));
    queue_request(make_byte(8'h7E));
    queue_request(make_start(MAX_PAYLOAD_BYTES + 1, 8'h80, 1'b1, 16'h0001));
    queue_request(make_start(1, 8'hC3, 1'b1, 16'h00FF));
    queue_request(make_byte(8'hE7));
    queue_request(make_start(3, 8'h10, 1'b0, 16'h1234));
    queue_request(make_byte(8'h11));
    queue_request(make_byte(8'h22));
    queue_request(make_byte(8'h33));
    wait_idle();

    set_station(16'hFFFF, 1'b1);
    run_phase(70, 0, 0);
    set_station(16'h0000, 1'b1);
    run_phase(70, 47, 0);
    set_station(ADDR_W'($urandom), 1'b0);
    run_phase(70, 0, 47);
    set_station(16'd9999, 1'b1);
    run_phase(70, 19, 19);

    // long receiver hold-off while requests keep coming
    set_station(16'hFFFF, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token++;
    queue_traffic(60);
    wait_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
